[hdl/rcst_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the refcounted slot table.
// No dependencies; imported by rcst_ram users and the top level.
package rcst_pkg;

  localparam int OPCODE_W   = 2;
  localparam int SLOT_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int REFCNT_W   = 16;
  localparam int LIMIT_W    = 9;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // valid bits examined per scan step
  localparam int CHUNK    = 16;
  localparam int CHUNK_LG = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ACQUIRE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_DONE
  } state_t;

  // packed so that status sits in the low bits
  typedef struct packed {
    logic                freed;
    logic [REFCNT_W-1:0] ref_count;
    logic [SLOT_W-1:0]   slot_out;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

[hdl/refcounted_slot_table_unit.sv]
`timescale 1ns / 1ps
// Top level of the refcounted slot table: sequencer, valid bits, scan unit.
// Depends on rcst_pkg and rcst_ram (count and auto-release flag storage).
//
// One request is handled at a time. Acquire and release go through the
// execute and done states before the next accept: the count RAM is read at
// accept, the single increment/decrement unit updates it and writes it back,
// then the result moves to the output register once that is free. Allocate
// scans the valid bits 16 slots per cycle through the 16-slot groups up to
// and including the one holding the first free slot (at most 16 for 256
// slots). The output register lets a new request be accepted while a
// result still waits on out_tready. No clearing pass is needed after
// reset: the valid bits clear at once and an entry of the count RAM is
// only used after an allocate has written it.
module refcounted_slot_table_unit
  import rcst_pkg::*;
#(
  parameter int SLOTS      = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // [1:0] opcode, [9:2] slot_id, [10] auto_free, [15:11] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] status, [9:2] slot_out, [25:10] ref_count, [26] freed, [31:27] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_W-1:0]     cfg_wr_data
);

  // slot numbers are 8 bits, so only the lowest 256 slots are reachable
  localparam int EFF    = (SLOTS < 256) ? SLOTS : 256;
  localparam int SW     = $clog2(EFF);
  localparam int NCHUNK = (EFF + CHUNK - 1) / CHUNK;
  localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int RAM_W  = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  state_t               state_r, state_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic [EFF-1:0]       valid_r, valid_nxt;
  logic [OPCODE_W-1:0]  op_r, op_nxt;
  logic [SLOT_W-1:0]    id_r, id_nxt;
  logic                 ar_r, ar_nxt;
  logic [CHW-1:0]       chunk_r, chunk_nxt;
  result_t              res_r, res_nxt;
  result_t              out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 accept;
  logic [OPCODE_W-1:0]  in_op;
  logic [SLOT_W-1:0]    in_id;
  logic                 in_ar;
  logic                 id_ok;

  logic [NCHUNK*CHUNK-1:0] occ;
  logic [CHUNK-1:0]        grp;
  logic                    hit;
  logic [CHUNK_LG-1:0]     hit_j;
  logic [LIMIT_W-1:0]      hit_slot;
  logic [LIMIT_W-1:0]      limit_eff;

  logic                  ram_we;
  logic [SW-1:0]         ram_waddr;
  logic [RAM_W-1:0]      ram_wdata;
  logic [RAM_W-1:0]      ram_rdata;

  logic [COUNT_BITS-1:0] cnt_cur, cnt_sum, cnt_new;
  logic                  cnt_en;
  logic [31:0]           cnt_ext;

  assign in_op = in_tdata[1:0];
  assign in_id = in_tdata[9:2];
  assign in_ar = in_tdata[10];

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_r};

  assign id_ok = ({1'b0, in_id} < LIMIT_W'(EFF)) && valid_r[in_id[SW-1:0]];
  assign limit_eff = (limit_r > LIMIT_W'(EFF)) ? LIMIT_W'(EFF) : limit_r;

  // scan group: slots past the table count as occupied
  always_comb begin
    occ = '1;
    occ[EFF-1:0] = valid_r;
    grp = occ[int'(chunk_r)*CHUNK +: CHUNK];
    hit   = 1'b0;
    hit_j = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (!grp[j]) begin
        hit   = 1'b1;
        hit_j = CHUNK_LG'(j);
      end
    end
    hit_slot = LIMIT_W'({chunk_r, hit_j});
  end

  // shared increment/decrement unit
  always_comb begin
    cnt_cur = ram_rdata[COUNT_BITS-1:0];
    if (op_r == OP_ACQUIRE) begin
      cnt_en  = (cnt_cur != CNT_MAX);
      cnt_sum = cnt_cur + COUNT_BITS'(1);
    end else begin
      cnt_en  = (cnt_cur != '0);
      cnt_sum = cnt_cur - COUNT_BITS'(1);
    end
    cnt_new = cnt_en ? cnt_sum : cnt_cur;
    cnt_ext = 32'(cnt_new);
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    ar_nxt        = ar_r;
    chunk_nxt     = chunk_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = id_r[SW-1:0];
    ram_wdata     = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_op;
          id_nxt    = in_id;
          ar_nxt    = in_ar;
          chunk_nxt = '0;
          if (in_op == OP_ALLOC) begin
            state_nxt = S_SCAN;
          end else if ((in_op == OP_ACQUIRE || in_op == OP_RELEASE) && id_ok) begin
            state_nxt = S_EXEC;
          end else begin
            res_nxt   = '{freed: 1'b0, ref_count: '0, slot_out: in_id, status: STAT_BAD};
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          // lowest free slot at or past the limit means none below it
          if (hit_slot < limit_eff) begin
            valid_nxt[hit_slot[SW-1:0]] = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = hit_slot[SW-1:0];
            ram_wdata = {ar_r, COUNT_BITS'(1)};
            res_nxt   = '{freed: 1'b0, ref_count: REFCNT_W'(1),
                          slot_out: hit_slot[SLOT_W-1:0], status: STAT_OK};
          end else begin
            res_nxt   = '{freed: 1'b0, ref_count: '0, slot_out: '0, status: STAT_FULL};
          end
          state_nxt = S_DONE;
        end else if (chunk_r == CHW'(NCHUNK - 1)) begin
          res_nxt   = '{freed: 1'b0, ref_count: '0, slot_out: '0, status: STAT_FULL};
          state_nxt = S_DONE;
        end else begin
          chunk_nxt = chunk_r + CHW'(1);
        end
      end
      S_EXEC: begin
        ram_we    = 1'b1;
        ram_waddr = id_r[SW-1:0];
        if (op_r == OP_RELEASE && cnt_new == '0 && ram_rdata[COUNT_BITS]) begin
          valid_nxt[id_r[SW-1:0]] = 1'b0;
          ram_wdata = '0;
          res_nxt   = '{freed: 1'b1, ref_count: '0, slot_out: id_r, status: STAT_OK};
        end else begin
          ram_wdata = {ram_rdata[COUNT_BITS], cnt_new};
          res_nxt   = '{freed: 1'b0,
                        ref_count: (cnt_ext > 32'h0000_FFFF) ? '1 : cnt_ext[REFCNT_W-1:0],
                        slot_out: id_r, status: STAT_OK};
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    id_r    <= id_nxt;
    ar_r    <= ar_nxt;
    chunk_r <= chunk_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  rcst_ram #(
    .WIDTH (RAM_W),
    .DEPTH (EFF)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (in_id[SW-1:0]),
    .rd_data (ram_rdata)
  );

endmodule

[hdl/rcst_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rcst_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[verif/tb_refcounted_slot_table_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_slot_table_unit: directed table and
// randomized phases at several slot limits. Depends on rcst_pkg.
module tb_refcounted_slot_table_unit
  import rcst_pkg::*;
();

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 24;   // longest allocate scan plus margin
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TABLE_DEPTH    = 256;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [LIMIT_W-1:0]     cfg_wr_data = '0;

  refcounted_slot_table_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // shadow copy of the slot table
  bit                  tbl_valid [TABLE_DEPTH];
  logic [REFCNT_W-1:0] tbl_count [TABLE_DEPTH];
  bit                  tbl_auto  [TABLE_DEPTH];
  logic [LIMIT_W-1:0]  alloc_limit = LIMIT_RESET;

  result_t pending_results[$];
  int errors      = 0;
  int n_checked   = 0;
  int n_alloc_ok  = 0;
  int n_full      = 0;
  int n_bad       = 0;
  int n_freed     = 0;
  int n_saturated = 0;
  int stuck_cycles = 0;
  bit tx_gaps_on  = 1'b0;
  bit rx_stalls_on = 1'b0;

  typedef struct {
    bit                  is_cfg;
    logic [LIMIT_W-1:0]  limit;
    logic [OPCODE_W-1:0] op;
    logic [SLOT_W-1:0]   id;
    logic                ar;
    bit                  typed;
    result_t             want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic result_t mk_res(logic [STATUS_W-1:0] st, int slot, int cnt, bit fr);
    result_t r;
    r.status    = st;
    r.slot_out  = SLOT_W'(slot);
    r.ref_count = REFCNT_W'(cnt);
    r.freed     = fr;
    return r;
  endfunction

  function automatic void add_req(logic [OPCODE_W-1:0] op, int id, bit ar, bit typed,
                                  result_t want);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.limit  = '0;
    row.op     = op;
    row.id     = SLOT_W'(id);
    row.ar     = ar;
    row.typed  = typed;
    row.want   = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(int limit);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.limit  = LIMIT_W'(limit);
    dir_rows.push_back(row);
  endfunction

  // applies one request to the shadow table and returns the expected result
  function automatic result_t predict_table_op(logic [OPCODE_W-1:0] op, logic [SLOT_W-1:0] id,
                                               logic ar);
    result_t r;
    int      lim;
    bit      found;
    r        = '0;
    r.status = STAT_BAD;
    r.slot_out = id;
    found    = 1'b0;
    if (op == OP_ALLOC) begin
      r.slot_out = '0;
      r.status   = STAT_FULL;
      lim = (alloc_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(alloc_limit);
      for (int i = 0; i < lim && !found; i++) begin
        if (!tbl_valid[i]) begin
          found        = 1'b1;
          tbl_valid[i] = 1'b1;
          tbl_count[i] = 1;
          tbl_auto[i]  = ar;
          r.status     = STAT_OK;
          r.slot_out   = SLOT_W'(i);
          r.ref_count  = 1;
        end
      end
    end else if (op != OP_UNUSED && tbl_valid[id]) begin
      r.status = STAT_OK;
      if (op == OP_ACQUIRE) begin
        if (tbl_count[id] != '1) tbl_count[id]++;
      end else begin
        if (tbl_count[id] != 0) tbl_count[id]--;
        if (tbl_count[id] == 0 && tbl_auto[id]) begin
          tbl_valid[id] = 1'b0;
          tbl_auto[id]  = 1'b0;
          r.freed       = 1'b1;
        end
      end
      r.ref_count = tbl_count[id];
    end
    if (r.status == STAT_FULL) n_full++;
    if (r.status == STAT_BAD) n_bad++;
    if (r.status == STAT_OK && op == OP_ALLOC) n_alloc_ok++;
    if (r.freed) n_freed++;
    if (r.ref_count == '1) n_saturated++;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_live_slot();
    int n;
    int k;
    n = 0;
    foreach (tbl_valid[i]) n += tbl_valid[i];
    if (n == 0) return -1;
    k = $urandom_range(0, n - 1);
    foreach (tbl_valid[i]) begin
      if (tbl_valid[i]) begin
        if (k == 0) return i;
        k--;
      end
    end
    return -1;
  endfunction

  // in_tvalid stays high after a transaction; callers lower it before waiting
  task automatic send_req(logic [OPCODE_W-1:0] op, logic [SLOT_W-1:0] id, logic ar,
                          bit typed, result_t want);
    int      gap;
    result_t model_res;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= IN_TDATA_W'({ar, id, op});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    model_res = predict_table_op(op, id, ar);
    pending_results.push_back(typed ? want : model_res);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_slot_limit(logic [LIMIT_W-1:0] limit);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    alloc_limit = limit;
  endtask

  // alloc_pct percent allocations, operations on live slots up to 90 percent, the rest noise
  task automatic run_phase(int limit, int alloc_pct, int n_items, bit busy);
    logic [OPCODE_W-1:0] op;
    logic [SLOT_W-1:0]   id;
    logic                ar;
    int                  r;
    int                  live;
    set_slot_limit(LIMIT_W'(limit));
    tx_gaps_on   = busy;
    rx_stalls_on = busy;
    repeat (n_items) begin
      r    = $urandom_range(0, 99);
      live = pick_live_slot();
      id   = SLOT_W'($urandom_range(0, 255));
      ar   = 1'($urandom_range(0, 1));
      if (r < alloc_pct) begin
        op = OP_ALLOC;
      end else if (r < 90 && live >= 0) begin
        op = $urandom_range(0, 1) ? OP_ACQUIRE : OP_RELEASE;
        id = SLOT_W'(live);
      end else begin
        op = OPCODE_W'($urandom_range(1, 3));
      end
      send_req(op, id, ar, 1'b0, '0);
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    n_checked++;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result status=%0d slot=%0d count=%0d freed=%0d",
               $time, got.status, got.slot_out, got.ref_count, got.freed);
      errors++;
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.slot_out !== want.slot_out) begin
        $display("%0t: slot_out mismatch, expected %0d, got %0d",
                 $time, want.slot_out, got.slot_out);
        errors++;
      end
      if (got.ref_count !== want.ref_count) begin
        $display("%0t: ref_count mismatch, expected %0d, got %0d",
                 $time, want.ref_count, got.ref_count);
        errors++;
      end
      if (got.freed !== want.freed) begin
        $display("%0t: freed mismatch, expected %0d, got %0d", $time, want.freed, got.freed);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_result(result_t'(out_tdata[$bits(result_t)-1:0]));
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stuck_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin : rx_side
    int n;
    forever begin
      if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        n = pick_gap();
        repeat (n + 1) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  end

  initial begin : stimulus
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_count[i] = '0;
      tbl_auto[i]  = 1'b0;
    end

    // directed rows; typed results follow from the table state by hand
    add_req(OP_ACQUIRE, 0,    0, 1, mk_res(STAT_BAD, 0, 0, 0));    // free slot
    add_req(OP_RELEASE, 255,  0, 1, mk_res(STAT_BAD, 255, 0, 0));
    add_req(OP_UNUSED,  'hAA, 1, 1, mk_res(STAT_BAD, 'hAA, 0, 0));
    add_req(OP_ALLOC,   0,    1, 1, mk_res(STAT_OK, 0, 1, 0));
    add_req(OP_ALLOC,   255,  0, 1, mk_res(STAT_OK, 1, 1, 0));
    add_req(OP_ACQUIRE, 0,    0, 1, mk_res(STAT_OK, 0, 2, 0));
    add_req(OP_RELEASE, 0,    0, 1, mk_res(STAT_OK, 0, 1, 0));
    add_req(OP_RELEASE, 0,    0, 1, mk_res(STAT_OK, 0, 0, 1));     // auto-release frees
    add_req(OP_RELEASE, 0,    0, 1, mk_res(STAT_BAD, 0, 0, 0));
    add_req(OP_RELEASE, 1,    0, 1, mk_res(STAT_OK, 1, 0, 0));     // stays valid at zero
    add_req(OP_RELEASE, 1,    1, 1, mk_res(STAT_OK, 1, 0, 0));     // release at zero
    add_req(OP_ACQUIRE, 1,    0, 1, mk_res(STAT_OK, 1, 1, 0));
    add_cfg(1);
    add_req(OP_ALLOC,   0,    1, 1, mk_res(STAT_OK, 0, 1, 0));
    add_req(OP_ALLOC,   0,    0, 1, mk_res(STAT_FULL, 0, 0, 0));
    add_cfg(2);
    add_req(OP_ALLOC,   'h5A, 1, 1, mk_res(STAT_FULL, 0, 0, 0));
    add_req(OP_ACQUIRE, 1,    1, 0, '0);
    add_cfg(256);
    add_req(OP_ALLOC,   'h55, 1, 1, mk_res(STAT_OK, 2, 1, 0));
    add_req(OP_UNUSED,  'h55, 0, 1, mk_res(STAT_BAD, 'h55, 0, 0));
    add_req(OP_RELEASE, 2,    0, 1, mk_res(STAT_OK, 2, 0, 1));
    add_cfg(1);
    add_req(OP_ACQUIRE, 1,    0, 0, '0);                          // valid slot above limit
    add_req(OP_RELEASE, 1,    1, 0, '0);
    add_req(OP_ALLOC,   0,    1, 0, '0);
    add_cfg(256);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        set_slot_limit(dir_rows[i].limit);
      else
        send_req(dir_rows[i].op, dir_rows[i].id, dir_rows[i].ar, dir_rows[i].typed,
                 dir_rows[i].want);
    end

    // short burst on slot 1 with no gaps and no stalls
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (2) send_req(OP_ACQUIRE, 8'd1, 1'b1, 1'b0, '0);
    send_req(OP_RELEASE, 8'd1, 1'b0, 1'b0, '0);

    run_phase(256, 40, 200, 1);
    run_phase(17,  50, 150, 1);
    run_phase(1,   30, 100, 1);
    run_phase(256, 85, 350, 1);   // fill the whole table
    run_phase(2,   40, 100, 0);
    run_phase(255, 30, 200, 1);
    run_phase(33,  50, 150, 1);
    run_phase($urandom_range(1, 256), 40, 150, 0);
    run_phase(16,  60, 150, 1);
    run_phase(256, 25, 150, 1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end

    $display("Checked %0d results: %0d allocations, %0d table full, %0d bad id or opcode,",
             n_checked, n_alloc_ok, n_full, n_bad);
    $display("%0d slots freed, %0d saturated counts, slot limits from 1 to 256; %0d errors",
             n_freed, n_saturated, errors);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
